### rtl/sst_pkg.sv
// Shared types and constants for the small set table block.
// Holds field widths, stream packing offsets, operation and status codes,
// and the command/status structs between controller and datapath.
package sst_pkg;

   localparam int OP_W       = 3;
   localparam int KEY_W      = 32;
   localparam int IDX_W      = 7;
   localparam int STAT_W     = 3;
   localparam int POS_W      = 6;
   localparam int ELEM_W     = 32;
   localparam int COUNT_W    = 7;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_IDX_LSB = KEY_W;
   localparam int REQ_PAD_W  = REQ_DATA_W - KEY_W - IDX_W;

   localparam int RSP_DATA_W    = 56;
   localparam int RSP_FOUND_LSB = STAT_W;
   localparam int RSP_POS_LSB   = RSP_FOUND_LSB + 1;
   localparam int RSP_ELEM_LSB  = RSP_POS_LSB + POS_W;
   localparam int RSP_COUNT_LSB = RSP_ELEM_LSB + ELEM_W;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_COUNT_LSB - COUNT_W;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 3'd0,
      OP_REMOVE = 3'd1,
      OP_SEARCH = 3'd2,
      OP_FIRST  = 3'd3,
      OP_NEXT   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 3'd0,
      STAT_DUP    = 3'd1,
      STAT_BADIDX = 3'd2,
      STAT_EMPTY  = 3'd3,
      STAT_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SHIFT,
      S_FETCH,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_PTR,
      RD_PTR_NEXT,
      RD_ZERO,
      RD_CURSOR
   } rd_src_type;

   typedef struct packed {
      logic       req_load;
      logic       res_clear;
      logic       res_status_en;
      status_type res_status;
      logic       res_found;
      logic       res_elem;
      logic       ptr_clear;
      logic       ptr_load_idx;
      logic       ptr_inc;
      logic       rd_req;
      rd_src_type rd_src;
      logic       cursor_step;
      logic       wr_append;
      logic       wr_shift;
      logic       fill_dec;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   fill_zero;
      logic   fill_full;
      logic   idx_bad;
      logic   cursor_bad;
      logic   scan_more;
      logic   shift_more;
      logic   rd_vld;
      logic   hit;
   } sts_type;

endpackage

### rtl/sst_ctrl.sv
// Controller state machine for the small set table.
// Sequences scan, shift and fetch steps and owns the result valid flag.
// Depends on sst_pkg.
module sst_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  sst_pkg::sts_type sts,
   output sst_pkg::cmd_type cmd
);
   import sst_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.rd_src   = RD_PTR;
      cmd.res_status = STAT_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_clear = 1'b1;
            unique case (sts.op)
               OP_ADD, OP_SEARCH: begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = S_SCAN;
               end
               OP_REMOVE: begin
                  if (sts.idx_bad) begin
                     cmd.res_status_en = 1'b1;
                     cmd.res_status    = STAT_BADIDX;
                     state_in          = S_FINISH;
                  end else begin
                     cmd.ptr_load_idx = 1'b1;
                     state_in         = S_SHIFT;
                  end
               end
               OP_FIRST: begin
                  if (sts.fill_zero) begin
                     cmd.res_status_en = 1'b1;
                     cmd.res_status    = STAT_EMPTY;
                     state_in          = S_FINISH;
                  end else begin
                     cmd.rd_req = 1'b1;
                     cmd.rd_src = RD_ZERO;
                     state_in   = S_FETCH;
                  end
               end
               OP_NEXT: begin
                  if (sts.fill_zero || sts.cursor_bad) begin
                     cmd.res_status_en = 1'b1;
                     cmd.res_status    = STAT_EMPTY;
                     state_in          = S_FINISH;
                  end else begin
                     cmd.rd_req      = 1'b1;
                     cmd.rd_src      = RD_CURSOR;
                     cmd.cursor_step = 1'b1;
                     state_in        = S_FETCH;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            priority if (sts.hit) begin
               if (sts.op == OP_ADD) begin
                  cmd.res_status_en = 1'b1;
                  cmd.res_status    = STAT_DUP;
               end else begin
                  cmd.res_found = 1'b1;
               end
               state_in = S_FINISH;
            end else if (sts.scan_more) begin
               cmd.rd_req  = 1'b1;
               cmd.rd_src  = RD_PTR;
               cmd.ptr_inc = 1'b1;
            end else begin
               if (sts.op == OP_ADD) begin
                  if (sts.fill_full) begin
                     cmd.res_status_en = 1'b1;
                     cmd.res_status    = STAT_FULL;
                  end else begin
                     cmd.wr_append = 1'b1;
                  end
               end
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.wr_shift = sts.rd_vld;
            if (sts.shift_more) begin
               cmd.rd_req  = 1'b1;
               cmd.rd_src  = RD_PTR_NEXT;
               cmd.ptr_inc = 1'b1;
            end else begin
               cmd.fill_dec = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FETCH: begin
            cmd.res_elem = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

### rtl/sst_dpath.sv
// Datapath for the small set table: key memory, fill count, cursor,
// scan pointer, compare stage, pending result and output register.
// Depends on sst_pkg.
module sst_dpath #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sst_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [sst_pkg::OP_W-1:0]         req_tuser,
   output logic [sst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  sst_pkg::cmd_type                 cmd,
   output sst_pkg::sts_type                 sts
);
   import sst_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;

   logic [KEY_WIDTH-1:0] mem [DEPTH];

   op_type               op_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [CW-1:0]        fill_ff, fill_in;
   logic [CW-1:0]        cursor_ff, cursor_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic                 rd_vld_ff;
   logic [AW-1:0]        rpos_ff;
   logic [KEY_WIDTH-1:0] rd_data_ff;

   status_type           stat_ff, stat_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [KEY_WIDTH-1:0] elem_ff, elem_in;
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic                 cursor_wrap;
   logic [CW-1:0]        ptr_next;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;

   assign cursor_wrap = (cursor_ff == fill_ff);
   assign ptr_next    = ptr_ff + 1'b1;

   always_comb begin
      sts.op         = op_ff;
      sts.fill_zero  = (fill_ff == '0);
      sts.fill_full  = (fill_ff == CW'(DEPTH));
      sts.idx_bad    = (XW'(idx_ff) >= XW'(fill_ff));
      sts.cursor_bad = (cursor_ff > fill_ff);
      sts.scan_more  = (ptr_ff < fill_ff);
      sts.shift_more = ({1'b0, ptr_ff} + 1'b1) < {1'b0, fill_ff};
      sts.rd_vld     = rd_vld_ff;
      sts.hit        = rd_vld_ff && (rd_data_ff == key_ff);
   end

   always_comb begin
      unique case (cmd.rd_src)
         RD_PTR:      rd_addr = ptr_ff[AW-1:0];
         RD_PTR_NEXT: rd_addr = ptr_next[AW-1:0];
         RD_ZERO:     rd_addr = '0;
         RD_CURSOR:   rd_addr = cursor_wrap ? '0 : cursor_ff[AW-1:0];
         default:     rd_addr = '0;
      endcase
   end

   assign wr_en   = cmd.wr_append || cmd.wr_shift;
   assign wr_addr = cmd.wr_append ? fill_ff[AW-1:0] : (rpos_ff - 1'b1);
   assign wr_data = cmd.wr_append ? key_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_req) begin
         rd_data_ff <= mem[rd_addr];
         rpos_ff    <= rd_addr;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.wr_append) begin
         fill_in = fill_ff + 1'b1;
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.cursor_step) begin
         cursor_in = cursor_wrap ? CW'(1) : (cursor_ff + 1'b1);
      end
   end

   always_comb begin
      priority if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_load_idx) begin
         ptr_in = CW'(idx_ff);
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_next;
      end else begin
         ptr_in = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         cursor_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         cursor_ff <= cursor_in;
         rd_vld_ff <= cmd.rd_req;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.req_load) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= KEY_WIDTH'(req_tdata[KEY_W-1:0]);
         idx_ff <= req_tdata[REQ_IDX_LSB +: IDX_W];
      end
   end

   always_comb begin
      stat_in  = stat_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      elem_in  = elem_ff;
      if (cmd.res_clear) begin
         stat_in  = STAT_OK;
         found_in = 1'b0;
         pos_in   = '0;
         elem_in  = '0;
      end
      if (cmd.res_status_en) begin
         stat_in = cmd.res_status;
      end
      if (cmd.res_found) begin
         found_in = 1'b1;
         pos_in   = rpos_ff;
      end
      if (cmd.res_elem) begin
         elem_in = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff  <= stat_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
      elem_ff  <= elem_in;
      if (cmd.out_load) begin
         rsp_ff <= {{RSP_PAD_W{1'b0}}, COUNT_W'(fill_ff), ELEM_W'(elem_ff),
                    POS_W'(pos_ff), found_ff, stat_ff};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

### rtl/small_set_table_core.sv
// Top level of the small set table: ordered table of distinct keys with
// linear search. Joins the controller and the datapath. Depends on sst_pkg.
// Add and search compare entries in order up to the count; remove shifts entries
// above the index down; first and next fetch one entry; bad index, empty, cursor
// errors and other codes end at once. One transaction at a time: the next request
// is taken in the cycle the result goes valid. A held result stalls the next one.
module small_set_table_core #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // key[31:0], index[38:32], zero pad
   input  logic [sst_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[2:0]
   input  logic [sst_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[2:0], found[3], position[9:4], element[41:10], count[48:42], pad
   output logic [sst_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sst_dpath #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

### rtl/sst_checker.sv
// Port-level checks for the small set table, bound to the top level.
// Depends on sst_pkg.
module sst_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sst_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sst_pkg::*;

   logic [STAT_W-1:0] rsp_stat;
   logic              rsp_found;
   logic [ELEM_W-1:0] rsp_elem;

   assign rsp_stat  = rsp_tdata[STAT_W-1:0];
   assign rsp_found = rsp_tdata[RSP_FOUND_LSB];
   assign rsp_elem  = rsp_tdata[RSP_ELEM_LSB +: ELEM_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in progress");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_found |-> rsp_stat == STAT_OK)
      else $error("found flag with error status");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_stat != STAT_OK |-> !rsp_found && rsp_elem == '0)
      else $error("error result carries data");

endmodule

bind small_set_table_core sst_checker u_sst_checker (.*);

### tb/sv/small_set_table_core_tb.sv
// Self-checking testbench for small_set_table_core: drives add, remove, search,
// first, next and undefined-code transactions and checks each result against an
// internal table predictor. Depends on sst_pkg and the small_set_table_core RTL.
module small_set_table_core_tb;
   import sst_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
   localparam int MAX_REPORTS  = 10;
   localparam int MAX_GAP      = 10;
   localparam int INDEX_MAX    = (1 << IDX_W) - 1;
   localparam int OP_MAX       = (1 << OP_W) - 1;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] index;
   } set_request_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic [POS_W-1:0]   position;
      logic [ELEM_W-1:0]  element;
      logic [COUNT_W-1:0] count;
   } set_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   set_request_type pending_items[$];
   set_result_type  expected_results[$];

   logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
   int tbl_count  = 0;
   int tbl_cursor = 0;

   bit req_fire  = 1'b0;
   bit rsp_fire  = 1'b0;
   bit req_busy  = 1'b0;
   int req_gap   = 0;
   int rsp_gap   = 0;
   bit calm_mode [2];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int issued         = 0;
   int random_stop    = 0;

   small_set_table_core #(
      .DEPTH     (TABLE_DEPTH),
      .KEY_WIDTH (KEY_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int draw_gap(input int side);
      if ($urandom_range(0, 29) == 0) calm_mode[side] = !calm_mode[side];
      return calm_mode[side] ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic set_result_type table_apply(input set_request_type it);
      set_result_type res;
      int hit;
      res = '0;
      res.status = STAT_OK;
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
         if (hit < 0 && tbl_keys[i] == it.key) hit = i;
      end
      case (it.op)
         OP_ADD: begin
            if (hit >= 0) begin
               res.status = STAT_DUP;
            end else if (tbl_count >= TABLE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               tbl_keys[tbl_count] = it.key;
               tbl_count++;
            end
         end
         OP_REMOVE: begin
            if (int'(it.index) >= tbl_count) begin
               res.status = STAT_BADIDX;
            end else begin
               for (int i = int'(it.index); i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i + 1];
               tbl_count--;
            end
         end
         OP_SEARCH: begin
            if (hit >= 0) begin
               res.found    = 1'b1;
               res.position = hit[POS_W-1:0];
            end
         end
         OP_FIRST: begin
            if (tbl_count == 0) res.status = STAT_EMPTY;
            else res.element = tbl_keys[0];
         end
         OP_NEXT: begin
            if (tbl_count == 0 || tbl_cursor > tbl_count) begin
               res.status = STAT_EMPTY;
            end else begin
               if (tbl_cursor == tbl_count) tbl_cursor = 0;
               tbl_cursor++;
               res.element = tbl_keys[tbl_cursor - 1];
            end
         end
         default: ;
      endcase
      res.count = tbl_count[COUNT_W-1:0];
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int choice;
      choice = $urandom_range(0, 3);
      if (choice == 0 && tbl_count > 0) return tbl_keys[$urandom_range(0, tbl_count - 1)];
      if (choice == 1) return KEY_W'($urandom_range(0, 31));
      return $urandom;
   endfunction

   task automatic push_item(input int op, input logic [KEY_W-1:0] key, input int index);
      set_request_type it;
      it.op    = op[OP_W-1:0];
      it.key   = key;
      it.index = index[IDX_W-1:0];
      while (pending_items.size() >= 2) @(posedge clock);
      pending_items = {pending_items, it};
      issued++;
   endtask

   task automatic push_random(input int add_w, input int remove_w);
      int roll;
      int pick;
      int index;
      if (issued >= random_stop) return;
      roll = $urandom_range(0, 99);
      if (tbl_count > 0 && $urandom_range(0, 4) != 0) index = $urandom_range(0, tbl_count - 1);
      else index = $urandom_range(0, INDEX_MAX);
      if (roll < add_w) begin
         push_item(OP_ADD, pick_key(), $urandom_range(0, INDEX_MAX));
      end else if (roll < add_w + remove_w) begin
         push_item(OP_REMOVE, $urandom, index);
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 4) push_item(OP_SEARCH, pick_key(), $urandom_range(0, INDEX_MAX));
         else if (pick == 4) push_item(OP_FIRST, $urandom, $urandom_range(0, INDEX_MAX));
         else if (pick < 9) push_item(OP_NEXT, $urandom, $urandom_range(0, INDEX_MAX));
         else push_item($urandom_range(OP_NEXT + 1, OP_MAX), $urandom, $urandom_range(0, INDEX_MAX));
      end
   endtask

   always @(posedge clock) begin
      set_result_type seen;
      set_result_type want;
      set_request_type taken;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         req_fire = !reset && req_tvalid && req_tready;
         rsp_fire = !reset && rsp_tvalid && rsp_tready;
         if (rsp_fire) begin
            seen.status   = status_type'(rsp_tdata[STAT_W-1:0]);
            seen.found    = rsp_tdata[RSP_FOUND_LSB];
            seen.position = rsp_tdata[RSP_POS_LSB +: POS_W];
            seen.element  = rsp_tdata[RSP_ELEM_LSB +: ELEM_W];
            seen.count    = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result transaction: tdata %h", rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("mismatch: expected status %0d found %0b pos %0d elem %h count %0d",
                              want.status, want.found, want.position, want.element, want.count,
                              " / got status %0d found %0b pos %0d elem %h count %0d",
                              seen.status, seen.found, seen.position, seen.element, seen.count);
               end
            end
         end
         if (req_fire) begin
            taken.op    = req_tuser;
            taken.key   = req_tdata[KEY_W-1:0];
            taken.index = req_tdata[REQ_IDX_LSB +: IDX_W];
            expected_results = {expected_results, table_apply(taken)};
         end
      end
   end

   always @(negedge clock) begin
      logic [REQ_DATA_W-1:0] word;
      set_request_type it;
      if (!reset) begin
         if (req_busy && req_fire) begin
            req_busy = 1'b0;
            req_gap  = draw_gap(0);
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_items.size() > 0) begin
               it   = pending_items.pop_front();
               word = '0;
               word[KEY_W-1:0]             = it.key;
               word[REQ_IDX_LSB +: IDX_W]  = it.index;
               req_tdata <= word;
               req_tuser <= it.op;
               req_busy = 1'b1;
            end
         end
         req_tvalid <= req_busy;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) rsp_gap = draw_gap(1);
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int random_start;
      int guard;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(OP_FIRST, 32'h0, 0);
      push_item(OP_NEXT, 32'h0, 0);
      push_item(OP_REMOVE, 32'h0, 0);
      push_item(OP_SEARCH, 32'h0, 0);
      for (int c = OP_NEXT + 1; c <= OP_MAX; c++) push_item(c, $urandom, $urandom_range(0, INDEX_MAX));
      push_item(OP_ADD, 32'h0, 0);
      push_item(OP_ADD, 32'hFFFF_FFFF, INDEX_MAX);
      push_item(OP_ADD, 32'h0, 0);
      push_item(OP_ADD, 32'h5A5A_5A5A, 0);
      push_item(OP_SEARCH, 32'hFFFF_FFFF, 0);
      push_item(OP_SEARCH, 32'h1234_5678, 0);
      push_item(OP_FIRST, 32'h0, 0);
      repeat (3) push_item(OP_NEXT, 32'h0, 0);
      push_item(OP_REMOVE, 32'h0, INDEX_MAX);
      push_item(OP_REMOVE, 32'h0, 3);
      push_item(OP_REMOVE, 32'hFFFF_FFFF, 0);
      push_item(OP_NEXT, 32'h0, 0);
      push_item(OP_ADD, 32'h0, 0);
      push_item(OP_NEXT, 32'h0, 0);
      push_item(OP_REMOVE, 32'h0, 2);
      push_item(OP_REMOVE, 32'h0, 0);

      random_start = issued;
      random_stop  = random_start + RANDOM_ITEMS;
      while (issued - random_start < RANDOM_ITEMS) begin
         guard = 0;
         while (tbl_count < TABLE_DEPTH && guard < 400) begin
            push_random(70, 5);
            guard++;
         end
         repeat (20) push_random(50, 5);
         repeat (120) push_random(30, 30);
         guard = 0;
         while (tbl_count > 0 && guard < 400) begin
            push_random(5, 70);
            guard++;
         end
         repeat (10) push_random(5, 70);
         repeat (80) push_random(40, 20);
      end

      do @(posedge clock);
      while (pending_items.size() != 0 || req_busy || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
